FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check prop at every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/irpdd_pkg.sv
package irpdd_pkg;

  localparam int INTERVAL_BITS = 16;
  localparam int IV_W          = 16;
  localparam int CFG_W         = 16;
  localparam int NUM_CFG       = 8;
  localparam int CFG_IDX_W     = $clog2(NUM_CFG);

  // Interval bits that take part in the decode
  localparam logic [IV_W-1:0] IV_MASK =
    (INTERVAL_BITS >= IV_W) ? {IV_W{1'b1}} : IV_W'((64'd1 << INTERVAL_BITS) - 64'd1);

  localparam logic [IV_W-1:0] ONE_SPACE_MAX    = 16'd1700;
  localparam logic [IV_W-1:0] REPEAT_SPACE_MAX = 16'd3000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_PULSE_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_PULSE_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE_MIN    = 3'd7;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    16'd6000, 16'd10000, 16'd3000, 16'd5000, 16'd1800, 16'd200, 16'd700, 16'd1500
  };

  // Result kinds
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_REPEAT  = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  localparam logic IN_CMD_EDGE    = 1'b0;
  localparam logic IN_CMD_TIMEOUT = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [IV_W-1:0] interval;
  } irpdd_in_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      address;
    logic [7:0]      command;
    logic [7:0]      address_check;
    logic [7:0]      command_check;
    logic [3:0]      fail_phase;
    logic [IV_W-1:0] fail_interval;
  } irpdd_out_t;

endpackage

FILE: hw/rtl/ir_pulse_distance_decoder.sv
// IR pulse-distance remote decoder.
// Input channel (in_valid / in_stall / in_data): one transaction per edge,
// carrying the ticks since the previous edge, or a timer-overflow timeout.
// Result channel (out_valid / out_stall / out_data): one transaction per
// decoded frame, repeat code or invalid interval; most inputs give none.
// Configuration: cfg_wr_en writes cfg_wdata to the timing window register
// selected by cfg_index; write only while the decoder is idle.
// Throughput: one input transaction per cycle while no result is held stalled.
// An accepted input is held in an input register and decoded there by a
// single pass of window compares and a bit write, whose result lands in the
// output register once out_stall allows it; out_valid shows that register.
// A stalled result holds the output register; the decode stage then holds
// and, with an input waiting, in_stall rises until the result is taken.
// Reset (synchronous, rst_n low): decoder returns to idle, stored bytes and
// last frame cleared, window registers take their default values.
`include "assert_macros.svh"

module ir_pulse_distance_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  irpdd_pkg::irpdd_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output irpdd_pkg::irpdd_out_t               out_data,
  input  logic                                cfg_wr_en,
  input  logic [irpdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpdd_pkg::CFG_W-1:0]         cfg_wdata
);
  import irpdd_pkg::*;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_LEAD_PULSE = 4'd1;
  localparam logic [3:0] PH_LEAD_SPACE = 4'd2;
  localparam logic [3:0] PH_BIT_PULSE0 = 4'd3;
  localparam logic [3:0] PH_BIT_SPACE0 = 4'd4;
  localparam logic [3:0] PH_BIT_PULSE1 = 4'd5;
  localparam logic [3:0] PH_BIT_SPACE1 = 4'd6;
  localparam logic [3:0] PH_BIT_PULSE2 = 4'd7;
  localparam logic [3:0] PH_BIT_SPACE2 = 4'd8;
  localparam logic [3:0] PH_BIT_PULSE3 = 4'd9;
  localparam logic [3:0] PH_BIT_SPACE3 = 4'd10;
  localparam logic [3:0] PH_FINAL      = 4'd11;

  logic [CFG_W-1:0] cfg_r [NUM_CFG];

  logic       in_valid_r;
  irpdd_in_t  in_item_r;
  logic       out_valid_r;
  irpdd_out_t out_item_r;

  logic [3:0] phase_r,    phase_nxt;
  logic [2:0] bit_pos_r,  bit_pos_nxt;
  logic [7:0] frame_r   [4];
  logic [7:0] frame_nxt [4];
  logic [7:0] last_addr_r, last_addr_nxt;
  logic [7:0] last_cmd_r,  last_cmd_nxt;
  logic       rpt_pend_r,  rpt_pend_nxt;

  logic       advance;
  logic       has_result;
  irpdd_out_t result;
  logic [IV_W-1:0] iv;
  logic       short_ok, one_ok, lead_pulse_ok, lead_space_ok, rpt_space_ok;
  logic [1:0] byte_idx;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  assign iv            = in_item_r.interval & IV_MASK;
  assign short_ok      = iv >= cfg_r[CFG_SHORT_MIN] && iv <= cfg_r[CFG_SHORT_MAX];
  assign one_ok        = iv >= cfg_r[CFG_ONE_SPACE_MIN] && iv <= ONE_SPACE_MAX;
  assign lead_pulse_ok = iv >= cfg_r[CFG_LEAD_PULSE_MIN] && iv <= cfg_r[CFG_LEAD_PULSE_MAX];
  assign lead_space_ok = iv >= cfg_r[CFG_LEAD_SPACE_MIN] && iv <= cfg_r[CFG_LEAD_SPACE_MAX];
  assign rpt_space_ok  = iv >= cfg_r[CFG_REPEAT_SPACE_MIN] && iv <= REPEAT_SPACE_MAX;
  // bit spaces 4/6/8/10 fill bytes 0..3
  assign byte_idx      = 2'(phase_r[3:1] - 3'd2);

  always_comb begin
    logic invalid;
    invalid       = 1'b0;
    has_result    = 1'b0;
    result        = '0;
    phase_nxt     = phase_r;
    bit_pos_nxt   = bit_pos_r;
    frame_nxt     = frame_r;
    last_addr_nxt = last_addr_r;
    last_cmd_nxt  = last_cmd_r;
    rpt_pend_nxt  = rpt_pend_r;

    if (in_item_r.cmd == IN_CMD_TIMEOUT) begin
      phase_nxt   = PH_IDLE;
      bit_pos_nxt = '0;
      frame_nxt   = '{default: '0};
    end else if (iv >= cfg_r[CFG_SHORT_MIN]) begin
      case (phase_r)
        PH_IDLE: begin
          phase_nxt = PH_LEAD_PULSE;
        end
        PH_LEAD_PULSE: begin
          if (lead_pulse_ok) phase_nxt = PH_LEAD_SPACE;
          else               invalid   = 1'b1;
        end
        PH_LEAD_SPACE: begin
          // leader space wins over repeat space where both fit
          if (lead_space_ok) begin
            rpt_pend_nxt = 1'b0;
            phase_nxt    = PH_BIT_PULSE0;
          end else if (rpt_space_ok) begin
            rpt_pend_nxt = 1'b1;
            phase_nxt    = PH_FINAL;
          end else begin
            invalid = 1'b1;
          end
        end
        PH_BIT_PULSE0, PH_BIT_PULSE1, PH_BIT_PULSE2, PH_BIT_PULSE3: begin
          if (short_ok) phase_nxt = phase_r + 4'd1;
          else          invalid   = 1'b1;
        end
        PH_BIT_SPACE0, PH_BIT_SPACE1, PH_BIT_SPACE2, PH_BIT_SPACE3: begin
          if (!(one_ok || short_ok)) begin
            invalid = 1'b1;
          end else begin
            if (one_ok) frame_nxt[byte_idx] = frame_r[byte_idx] | (8'd1 << bit_pos_r);
            if (bit_pos_r == 3'd7) begin
              phase_nxt   = phase_r + 4'd1;
              bit_pos_nxt = '0;
            end else begin
              phase_nxt   = phase_r - 4'd1;
              bit_pos_nxt = bit_pos_r + 3'd1;
            end
          end
        end
        PH_FINAL: begin
          if (!short_ok) begin
            invalid = 1'b1;
          end else if (rpt_pend_r) begin
            has_result     = 1'b1;
            result.kind    = KIND_REPEAT;
            result.address = last_addr_r;
            result.command = last_cmd_r;
            phase_nxt      = PH_IDLE;
          end else if (~frame_r[0] == frame_r[1] && ~frame_r[2] == frame_r[3]) begin
            has_result           = 1'b1;
            result.kind          = KIND_FRAME;
            result.address       = frame_r[0];
            result.command       = frame_r[2];
            result.address_check = frame_r[1];
            result.command_check = frame_r[3];
            last_addr_nxt        = frame_r[0];
            last_cmd_nxt         = frame_r[2];
            phase_nxt            = PH_IDLE;
            bit_pos_nxt          = '0;
            frame_nxt            = '{default: '0};
          end else begin
            invalid = 1'b1;
          end
        end
        default: begin
          invalid = 1'b1;
        end
      endcase
    end

    if (invalid) begin
      has_result           = 1'b1;
      result.kind          = KIND_INVALID;
      result.address       = frame_r[0];
      result.command       = frame_r[2];
      result.address_check = frame_r[1];
      result.command_check = frame_r[3];
      result.fail_phase    = phase_r;
      result.fail_interval = iv;
      phase_nxt            = PH_IDLE;
      bit_pos_nxt          = '0;
      frame_nxt            = '{default: '0};
      last_addr_nxt        = '0;
      last_cmd_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      bit_pos_r   <= '0;
      frame_r     <= '{default: '0};
      last_addr_r <= '0;
      last_cmd_r  <= '0;
      rpt_pend_r  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r && has_result;
      end
      // advance the decoder only on a transaction that leaves the input register
      if (in_valid_r && advance) begin
        phase_r     <= phase_nxt;
        bit_pos_r   <= bit_pos_nxt;
        frame_r     <= frame_nxt;
        last_addr_r <= last_addr_nxt;
        last_cmd_r  <= last_cmd_nxt;
        rpt_pend_r  <= rpt_pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (in_valid_r && advance && has_result) begin
      out_item_r <= result;
    end
  end

  `ASSERT_CLK(a_bitpos_in_bits, clk, rst_n,
    (bit_pos_r != 3'd0) |-> (phase_r >= PH_BIT_PULSE0 && phase_r <= PH_BIT_SPACE3),
    "bit position set outside the bit cells")
  `ASSERT_CLK(a_stall_cause, clk, rst_n,
    in_stall |-> (out_valid_r && out_stall && in_valid_r),
    "input stalled without a held result")
  `ASSERT_CLK(a_frame_saved, clk, rst_n,
    (out_valid_r && out_item_r.kind == KIND_FRAME) |->
      (last_addr_r == out_item_r.address && last_cmd_r == out_item_r.command),
    "shown frame not kept as last frame")

endmodule

FILE: tb/sv/irpdd_report_checker.sv
`timescale 1ns / 1ps

module irpdd_report_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  irpdd_pkg::irpdd_in_t             in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  irpdd_pkg::irpdd_out_t            out_data,
  input  logic                             cfg_wr_en,
  input  logic [irpdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpdd_pkg::CFG_W-1:0]      cfg_wdata,
  output int                               mismatch_count,
  output int                               awaiting,
  output int                               reports_seen
);
  import irpdd_pkg::*;

  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_LEAD_PULSE  = 4'd1;
  localparam logic [3:0] PH_LEAD_SPACE  = 4'd2;
  localparam logic [3:0] PH_FIRST_PULSE = 4'd3;
  localparam logic [3:0] PH_FINAL       = 4'd11;

  logic [CFG_W-1:0] windows [NUM_CFG];
  logic [3:0]       phase;
  logic [2:0]       bit_pos;
  logic [7:0]       frame_bytes [4];
  logic [7:0]       last_addr;
  logic [7:0]       last_cmd;
  logic             repeat_pend;
  irpdd_out_t       awaited_reports [$];
  int               errors = 0;
  int               taken  = 0;

  function automatic bit fits(input logic [IV_W-1:0] v, input logic [IV_W-1:0] lo,
                              input logic [IV_W-1:0] hi);
    return v >= lo && v <= hi;
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < 4; i++) frame_bytes[i] = 8'd0;
    bit_pos = 3'd0;
    phase   = PH_IDLE;
  endtask

  task automatic push_report(input logic [1:0] kind, input logic [7:0] addr,
                             input logic [7:0] command, input logic [7:0] addr_chk,
                             input logic [7:0] cmd_chk, input logic [3:0] bad_phase,
                             input logic [IV_W-1:0] bad_iv);
    irpdd_out_t r;
    r.kind          = kind;
    r.address       = addr;
    r.command       = command;
    r.address_check = addr_chk;
    r.command_check = cmd_chk;
    r.fail_phase    = bad_phase;
    r.fail_interval = bad_iv;
    awaited_reports.push_back(r);
  endtask

  // Report the partial frame, then drop it together with the last good frame
  task automatic report_bad_interval(input logic [IV_W-1:0] iv);
    push_report(KIND_INVALID, frame_bytes[0], frame_bytes[2], frame_bytes[1],
                frame_bytes[3], phase, iv);
    clear_frame();
    last_addr = 8'd0;
    last_cmd  = 8'd0;
  endtask

  task automatic decode_edge(input irpdd_in_t t);
    logic [IV_W-1:0] iv;
    logic            short_ok;
    logic            one;
    logic [1:0]      sel;
    iv = t.interval & IV_MASK;
    if (t.cmd == IN_CMD_TIMEOUT) begin
      clear_frame();
      return;
    end
    if (iv < windows[CFG_SHORT_MIN]) return;
    short_ok = fits(iv, windows[CFG_SHORT_MIN], windows[CFG_SHORT_MAX]);
    case (phase)
      PH_IDLE: phase = PH_LEAD_PULSE;
      PH_LEAD_PULSE: begin
        if (fits(iv, windows[CFG_LEAD_PULSE_MIN], windows[CFG_LEAD_PULSE_MAX]))
          phase = PH_LEAD_SPACE;
        else
          report_bad_interval(iv);
      end
      PH_LEAD_SPACE: begin
        // leader space wins over repeat space where the two overlap
        if (fits(iv, windows[CFG_LEAD_SPACE_MIN], windows[CFG_LEAD_SPACE_MAX])) begin
          repeat_pend = 1'b0;
          phase       = PH_FIRST_PULSE;
        end else if (fits(iv, windows[CFG_REPEAT_SPACE_MIN], REPEAT_SPACE_MAX)) begin
          repeat_pend = 1'b1;
          phase       = PH_FINAL;
        end else begin
          report_bad_interval(iv);
        end
      end
      PH_FINAL: begin
        if (!short_ok) begin
          report_bad_interval(iv);
        end else if (repeat_pend) begin
          push_report(KIND_REPEAT, last_addr, last_cmd, 8'd0, 8'd0, 4'd0, '0);
          phase = PH_IDLE;
        end else if (frame_bytes[1] == ~frame_bytes[0] &&
                     frame_bytes[3] == ~frame_bytes[2]) begin
          push_report(KIND_FRAME, frame_bytes[0], frame_bytes[2], frame_bytes[1],
                      frame_bytes[3], 4'd0, '0);
          last_addr = frame_bytes[0];
          last_cmd  = frame_bytes[2];
          clear_frame();
        end else begin
          report_bad_interval(iv);
        end
      end
      default: begin
        if (phase < PH_FIRST_PULSE || phase > PH_FINAL) begin
          report_bad_interval(iv);
        end else if (phase[0]) begin
          // bit pulse
          if (short_ok) phase = phase + 4'd1;
          else report_bad_interval(iv);
        end else begin
          // bit space: a one takes precedence over a zero
          one = fits(iv, windows[CFG_ONE_SPACE_MIN], ONE_SPACE_MAX);
          if (!(one || short_ok)) begin
            report_bad_interval(iv);
          end else begin
            sel = 2'(phase[3:1] - 3'd2);
            if (one) frame_bytes[sel][bit_pos] = 1'b1;
            if (bit_pos == 3'd7) begin
              phase   = phase + 4'd1;
              bit_pos = 3'd0;
            end else begin
              phase   = phase - 4'd1;
              bit_pos = bit_pos + 3'd1;
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    irpdd_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) windows[i] = CFG_RESET[i];
      clear_frame();
      last_addr   = 8'd0;
      last_cmd    = 8'd0;
      repeat_pend = 1'b0;
      awaited_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        taken++;
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected report: expected none, got kind %0d addr 0x%0h cmd 0x%0h",
                   $time, out_data.kind, out_data.address, out_data.command);
          errors++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("address", want.address, out_data.address);
          check_field("command", want.command, out_data.command);
          check_field("address_check", want.address_check, out_data.address_check);
          check_field("command_check", want.command_check, out_data.command_check);
          check_field("fail_phase", want.fail_phase, out_data.fail_phase);
          check_field("fail_interval", want.fail_interval, out_data.fail_interval);
        end
      end
      if (in_valid && !in_stall) decode_edge(in_data);
      if (cfg_wr_en) windows[cfg_index] = cfg_wdata;
    end
    mismatch_count <= errors;
    awaiting       <= awaited_reports.size();
    reports_seen   <= taken;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import irpdd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  irpdd_in_t            in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  irpdd_out_t           out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int               mismatch_count;
  int               awaiting;
  int               reports_seen;
  int               cycles     = 0;
  int               stall_left = 0;
  int               items_sent = 0;
  int               settings   = 0;
  int               spoil_at   = -1;
  int               seq_pos    = 0;
  logic             calm       = 1'b0;
  logic [CFG_W-1:0] cur_cfg [NUM_CFG];

  always #10 clk = ~clk;

  ir_pulse_distance_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  irpdd_report_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .awaiting       (awaiting),
    .reports_seen   (reports_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run hit the cycle limit", $time);
      $display("ir_pulse_distance_decoder regression: fail");
      $finish;
    end
  end

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic cmd, input logic [IV_W-1:0] ticks);
    irpdd_in_t item;
    item.cmd      = cmd;
    item.interval = ticks;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == IN_CMD_TIMEOUT || ticks >= cur_cfg[CFG_SHORT_MIN]) items_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold the sender until every awaited report is in, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_windows();
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= cur_cfg[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  function automatic logic [IV_W-1:0] pick(input int lo, input int hi);
    if (hi < lo) return IV_W'(lo);
    return IV_W'($urandom_range(hi, lo));
  endfunction

  // One edge of a well-formed sequence; the chosen position gets spoilt
  task automatic send_timed(input logic [IV_W-1:0] ticks);
    if (seq_pos == spoil_at) begin
      case ($urandom_range(0, 2))
        0: send_item(IN_CMD_EDGE, IV_W'($urandom_range(0, 65535)));
        1: send_item(IN_CMD_TIMEOUT, ticks);
        default: ;
      endcase
    end else begin
      send_item(IN_CMD_EDGE, ticks);
    end
    seq_pos++;
  endtask

  task automatic send_frame(input bit is_repeat, input bit mangle);
    logic [7:0] frame [4];
    int         smin;
    int         smax;
    smin     = cur_cfg[CFG_SHORT_MIN];
    smax     = cur_cfg[CFG_SHORT_MAX];
    seq_pos  = 0;
    spoil_at = mangle ? $urandom_range(0, is_repeat ? 3 : 67) : -1;
    if ($urandom_range(0, 1)) send_item(IN_CMD_TIMEOUT, IV_W'($urandom_range(0, 65535)));
    send_timed(pick(smin, 65535));
    send_timed(pick(cur_cfg[CFG_LEAD_PULSE_MIN], cur_cfg[CFG_LEAD_PULSE_MAX]));
    if (is_repeat) begin
      send_timed(pick(cur_cfg[CFG_REPEAT_SPACE_MIN], REPEAT_SPACE_MAX));
    end else begin
      send_timed(pick(cur_cfg[CFG_LEAD_SPACE_MIN], cur_cfg[CFG_LEAD_SPACE_MAX]));
      frame[0] = 8'($urandom);
      frame[1] = ~frame[0];
      frame[2] = 8'($urandom);
      frame[3] = ~frame[2];
      if ($urandom_range(0, 7) == 0)
        frame[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      for (int k = 0; k < 32; k++) begin
        send_timed(pick(smin, smax));
        if (frame[k / 8][k % 8]) send_timed(pick(cur_cfg[CFG_ONE_SPACE_MIN], ONE_SPACE_MAX));
        else send_timed(pick(smin, smax));
      end
    end
    send_timed(pick(smin, smax));
    spoil_at = -1;
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_frame(1'b0, $urandom_range(0, 3) == 0);
        5, 6: send_frame(1'b1, $urandom_range(0, 3) == 0);
        7: begin
          if (cur_cfg[CFG_SHORT_MIN] != 0)
            repeat ($urandom_range(1, 3))
              send_item(IN_CMD_EDGE, pick(0, cur_cfg[CFG_SHORT_MIN] - 1));
        end
        8: send_item(1'($urandom_range(0, 1)), IV_W'($urandom_range(0, 65535)));
        default: send_item(IN_CMD_TIMEOUT, IV_W'($urandom_range(0, 65535)));
      endcase
      if ($urandom_range(0, 40) == 0) settle();
    end
  endtask

  task automatic use_defaults();
    for (int i = 0; i < NUM_CFG; i++) cur_cfg[i] = CFG_RESET[i];
  endtask

  initial begin
    use_defaults();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // noise, then a leader pulse far too long
    send_item(IN_CMD_EDGE, 16'd0);
    send_item(IN_CMD_EDGE, 16'hFFFF);
    send_item(IN_CMD_EDGE, 16'hFFFF);
    send_item(IN_CMD_TIMEOUT, 16'hFFFF);
    // repeat code before any frame
    send_item(IN_CMD_EDGE, 16'd1000);
    send_item(IN_CMD_EDGE, 16'd9000);
    send_item(IN_CMD_EDGE, 16'd2250);
    send_item(IN_CMD_EDGE, 16'd560);
    // space on the shared leader/repeat bound, then a bad bit pulse
    send_item(IN_CMD_EDGE, 16'd1000);
    send_item(IN_CMD_EDGE, 16'd9000);
    send_item(IN_CMD_EDGE, 16'd3000);
    send_item(IN_CMD_EDGE, 16'hFFFF);
    // leader pulse just short
    send_item(IN_CMD_EDGE, 16'd1000);
    send_item(IN_CMD_EDGE, 16'd5999);
    // timeout in the middle of a frame
    send_item(IN_CMD_EDGE, 16'd1000);
    send_item(IN_CMD_EDGE, 16'd9000);
    send_item(IN_CMD_EDGE, 16'd4500);
    send_item(IN_CMD_EDGE, 16'd560);
    send_item(IN_CMD_TIMEOUT, 16'd0);
    // bit space between the zero and one windows
    send_item(IN_CMD_EDGE, 16'd1000);
    send_item(IN_CMD_EDGE, 16'd10000);
    send_item(IN_CMD_EDGE, 16'd5000);
    send_item(IN_CMD_EDGE, 16'd700);
    send_item(IN_CMD_EDGE, 16'd1000);
    settle();

    load_windows();
    random_phase(550);
    settle();

    // zero and one space windows overlap
    cur_cfg[CFG_SHORT_MAX]     = 16'd1600;
    cur_cfg[CFG_ONE_SPACE_MIN] = 16'd1500;
    load_windows();
    random_phase(200);
    settle();

    for (int i = 0; i < NUM_CFG; i++) cur_cfg[i] = 16'd0;
    load_windows();
    random_phase(120);
    settle();

    // leader and short windows as wide as they go
    cur_cfg[CFG_LEAD_PULSE_MAX] = 16'hFFFF;
    cur_cfg[CFG_LEAD_SPACE_MAX] = 16'hFFFF;
    cur_cfg[CFG_SHORT_MAX]      = 16'hFFFF;
    load_windows();
    random_phase(120);
    settle();

    for (int i = 0; i < NUM_CFG; i++) cur_cfg[i] = 16'hFFFF;
    load_windows();
    random_phase(60);
    settle();

    for (int i = 0; i < NUM_CFG; i++) cur_cfg[i] = CFG_W'($urandom_range(0, 65535));
    load_windows();
    random_phase(100);
    settle();

    // defaults with wide jitter on every window register
    use_defaults();
    for (int i = 0; i < NUM_CFG; i++)
      cur_cfg[i] = CFG_W'(int'(CFG_RESET[i]) + $urandom_range(0, 400) - 200);
    load_windows();
    random_phase(100);
    settle();

    // back to defaults; last stretch runs without idling
    use_defaults();
    load_windows();
    calm <= 1'b1;
    random_phase(200);
    settle();

    $display("covered %0d input transactions and %0d decoded reports", items_sent, reports_seen);
    $display("over %0d timing settings, with idling and back-pressure on both channels",
             settings);
    if (awaiting != 0) $display("%0t: %0d expected reports never arrived", $time, awaiting);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("ir_pulse_distance_decoder regression: pass");
    end else begin
      $display("ir_pulse_distance_decoder regression: fail");
    end
    $finish;
  end

endmodule
